// ----- hdl/dfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dfp_pkg;

    localparam int MAX_FRAGMENTS     = 64;
    localparam int FRAG_HEADER_BYTES = 5;
    localparam int MAX_DGRAM_LEN     = 2047;

    localparam logic [4:0] DISPATCH_FIRST = 5'h18;
    localparam logic [4:0] DISPATCH_LATER = 5'h1C;

    localparam logic REG_MAX_PHY_PACKET     = 1'b0;
    localparam logic REG_MAX_FRAME_OVERHEAD = 1'b1;

    localparam logic [6:0] MAX_PHY_PACKET_RESET     = 7'd127;
    localparam logic [6:0] MAX_FRAME_OVERHEAD_RESET = 7'd25;

    typedef struct packed {
        logic capture;
        logic calc_space;
        logic start;
        logic load_err;
        logic load_frag;
    } dfp_cmd_t;

    typedef struct packed {
        logic err;
        logic last;
    } dfp_status_t;

endpackage

`default_nettype wire

// ----- hdl/dfp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dfp_ctrl
    import dfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire dfp_status_t status,
    output dfp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPACE,
        ST_CHECK,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SPACE;
                end
            end
            ST_SPACE:
            begin
                cmd.calc_space = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.err)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = ST_SEND;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_frag = 1'b1;
                state_next    = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_frag = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);

`ifndef SYNTHESIS
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.last) |=> in_ready)
        else $error("Controller did not return to idle after the last beat.");

    a_check_leads_on: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |=> (out_valid || state_reg == ST_LOAD))
        else $error("Check step did not lead to a load or a result.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input accepted while a result is pending.");
`endif

endmodule

`default_nettype wire

// ----- hdl/dfp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dfp_datapath
    import dfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic [10:0] payload_length,
    input  wire logic [5:0]  compressed_header_size,
    input  wire logic [6:0]  link_overhead,
    input  wire dfp_cmd_t    cmd,
    output dfp_status_t      status,
    output logic [15:0]      size_word,
    output logic [15:0]      frag_tag,
    output logic [7:0]       offset_units,
    output logic [10:0]      source_offset,
    output logic [6:0]       fragment_length,
    output logic [6:0]       frame_length,
    output logic             last,
    output logic             error
);

    logic [6:0]  max_phy_packet_reg;
    logic [6:0]  max_frame_overhead_reg;
    logic [15:0] tag_reg;
    logic [11:0] dlen_reg;
    logic [7:0]  hdr_reg;
    logic [6:0]  space_reg;
    logic [10:0] off_reg;
    logic [10:0] rem_reg;

    logic [15:0] size_word_reg;
    logic [15:0] tag_out_reg;
    logic [10:0] source_offset_reg;
    logic [6:0]  fragment_length_reg;
    logic [6:0]  frame_length_reg;
    logic        last_reg;
    logic        error_reg;

    logic [7:0]  hdr_sum;
    logic [7:0]  comp_ext;
    logic [7:0]  hdr_next;
    logic [8:0]  space_need;
    logic [8:0]  space_diff;
    logic [6:0]  space_next;
    logic [12:0] frag_limit;
    logic        err_now;
    logic        is_last;
    logic [6:0]  flen;
    logic [4:0]  dispatch;

    always_comb
    begin
        hdr_sum  = {1'b0, link_overhead} + 8'(FRAG_HEADER_BYTES - 1);
        comp_ext = {2'b00, compressed_header_size};
        hdr_next = (hdr_sum > comp_ext) ? (hdr_sum - comp_ext) : 8'd0;

        space_need = {2'b00, max_frame_overhead_reg} + {1'b0, hdr_reg};
        space_diff = {2'b00, max_phy_packet_reg} - space_need;
        space_next = ({2'b00, max_phy_packet_reg} > space_need)
                   ? {space_diff[6:3], 3'b000} : 7'd0;

        frag_limit = 13'(space_reg) * 13'(MAX_FRAGMENTS);
        err_now    = (space_reg == 7'd0) || (dlen_reg > 12'(MAX_DGRAM_LEN))
                   || ({1'b0, dlen_reg} > frag_limit);

        is_last  = (rem_reg <= {4'd0, space_reg});
        flen     = is_last ? rem_reg[6:0] : space_reg;
        dispatch = (off_reg == 11'd0) ? DISPATCH_FIRST : DISPATCH_LATER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_phy_packet_reg     <= MAX_PHY_PACKET_RESET;
            max_frame_overhead_reg <= MAX_FRAME_OVERHEAD_RESET;
            tag_reg                <= 16'd0;
            off_reg                <= 11'd0;
            rem_reg                <= 11'd0;
            space_reg              <= 7'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MAX_PHY_PACKET:     max_phy_packet_reg     <= cfg_wr_data;
                    REG_MAX_FRAME_OVERHEAD: max_frame_overhead_reg <= cfg_wr_data;
                    default:                max_phy_packet_reg     <= max_phy_packet_reg;
                endcase
            end
            if (cmd.calc_space)
            begin
                space_reg <= space_next;
            end
            if (cmd.start)
            begin
                tag_reg <= tag_reg + 16'd1;
                off_reg <= 11'd0;
                rem_reg <= dlen_reg[10:0];
            end
            if (cmd.load_frag)
            begin
                off_reg <= off_reg + 11'(flen);
                rem_reg <= rem_reg - 11'(flen);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dlen_reg <= 12'(payload_length) + 12'(compressed_header_size);
            hdr_reg  <= hdr_next;
        end
        if (cmd.load_err)
        begin
            size_word_reg       <= 16'd0;
            tag_out_reg         <= 16'd0;
            source_offset_reg   <= 11'd0;
            fragment_length_reg <= 7'd0;
            frame_length_reg    <= 7'd0;
            last_reg            <= 1'b1;
            error_reg           <= 1'b1;
        end
        else if (cmd.load_frag)
        begin
            size_word_reg       <= {dispatch, dlen_reg[10:0]};
            tag_out_reg         <= tag_reg;
            source_offset_reg   <= off_reg;
            fragment_length_reg <= flen;
            frame_length_reg    <= hdr_reg[6:0] + flen;
            last_reg            <= is_last;
            error_reg           <= 1'b0;
        end
    end

    assign status.err      = err_now;
    assign status.last     = last_reg;
    assign size_word       = size_word_reg;
    assign frag_tag        = tag_out_reg;
    assign offset_units    = source_offset_reg[10:3];
    assign source_offset   = source_offset_reg;
    assign fragment_length = fragment_length_reg;
    assign frame_length    = frame_length_reg;
    assign last            = last_reg;
    assign error           = error_reg;

endmodule

`default_nettype wire

// ----- hdl/datagram_fragment_planner_unit.sv -----
// Sequence: a request accepted in idle passes through the space and check steps, then a load
// step that registers the first fragment beat; an error result is registered by the check step.
// Throughput: one fragment beat per cycle while out_ready is high; a request holds the block,
// with in_ready low, from its acceptance through the setup steps of the controller until its
// last beat is taken.
// Reset: asynchronous, active low; the tag counter clears to zero and the registers return
// to a packet size of 127 and a frame overhead of 25.
`timescale 1ns / 1ps
`default_nettype none

module datagram_fragment_planner_unit
    import dfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [10:0] payload_length,
    input  wire logic [5:0]  compressed_header_size,
    input  wire logic [6:0]  link_overhead,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      size_word,
    output logic [15:0]      frag_tag,
    output logic [7:0]       offset_units,
    output logic [10:0]      source_offset,
    output logic [6:0]       fragment_length,
    output logic [6:0]       frame_length,
    output logic             last,
    output logic             error
);

    dfp_cmd_t    cmd;
    dfp_status_t status;

    dfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dfp_datapath u_datapath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wr_data            (cfg_wr_data),
        .payload_length         (payload_length),
        .compressed_header_size (compressed_header_size),
        .link_overhead          (link_overhead),
        .cmd                    (cmd),
        .status                 (status),
        .size_word              (size_word),
        .frag_tag               (frag_tag),
        .offset_units           (offset_units),
        .source_offset          (source_offset),
        .fragment_length        (fragment_length),
        .frame_length           (frame_length),
        .last                   (last),
        .error                  (error)
    );

endmodule

`default_nettype wire

// ----- sim/datagram_fragment_planner_unit_tb.sv -----
`timescale 1ns / 1ps

module datagram_fragment_planner_unit_tb;
    import dfp_pkg::*;

    typedef struct packed {
        logic [15:0] size_word;
        logic [15:0] tag;
        logic [7:0]  off_units;
        logic [10:0] src_off;
        logic [6:0]  frag_len;
        logic [6:0]  frame_len;
        logic        is_last;
        logic        is_err;
    } frag_desc_t;

    typedef struct packed {
        logic [10:0] pay;
        logic [5:0]  comp;
        logic [6:0]  link;
        logic        typed;
        frag_desc_t  want;
    } request_row_t;

    localparam frag_desc_t ERR_DESC =
        '{16'd0, 16'd0, 8'd0, 11'd0, 7'd0, 7'd0, 1'b1, 1'b1};
    localparam frag_desc_t EMPTY_FIRST_DESC =
        '{{DISPATCH_FIRST, 11'd0}, 16'd1, 8'd0, 11'd0, 7'd0, 7'd4, 1'b1, 1'b0};
    localparam frag_desc_t NO_DESC = '0;
    localparam int DIRECTED_ROWS = 18;
    localparam int SQUEEZE_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_MAX_PHY_PACKET;
    logic [6:0]  cfg_wr_data = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [10:0] payload_length = 11'd0;
    logic [5:0]  compressed_header_size = 6'd0;
    logic [6:0]  link_overhead = 7'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] size_word;
    logic [15:0] frag_tag;
    logic [7:0]  offset_units;
    logic [10:0] source_offset;
    logic [6:0]  fragment_length;
    logic [6:0]  frame_length;
    logic        last;
    logic        error;

    frag_desc_t   frag_q[$];
    request_row_t dir_rows[DIRECTED_ROWS];
    logic [6:0]   phy_size = MAX_PHY_PACKET_RESET;
    logic [6:0]   ovh_size = MAX_FRAME_OVERHEAD_RESET;
    logic [15:0]  tag_ctr = 16'd0;
    int           mismatches = 0;
    bit           gap_mode = 1'b0;
    bit           sink_mode = 1'b0;
    bit           squeeze = 1'b0;

    datagram_fragment_planner_unit u_top (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wr_data            (cfg_wr_data),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .payload_length         (payload_length),
        .compressed_header_size (compressed_header_size),
        .link_overhead          (link_overhead),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .size_word              (size_word),
        .frag_tag               (frag_tag),
        .offset_units           (offset_units),
        .source_offset          (source_offset),
        .fragment_length        (fragment_length),
        .frame_length           (frame_length),
        .last                   (last),
        .error                  (error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    // Splits one datagram into fragment descriptors and queues them when record is set.
    function automatic void plan_datagram(input logic [10:0] pay, input logic [5:0] comp,
                                          input logic [6:0] link, input bit record);
        int dlen;
        int hdr;
        int space;
        int count;
        int off;
        int rem;
        int flen;
        bit bad;
        frag_desc_t d;
        dlen = int'(comp) + int'(pay);
        hdr = int'(link) + FRAG_HEADER_BYTES - int'(comp) - 1;
        if (hdr < 0)
            hdr = 0;
        space = int'(phy_size) - int'(ovh_size) - hdr;
        if (space < 0)
            space = 0;
        space -= space % 8;
        count = 1;
        bad = (space == 0) || (dlen > MAX_DGRAM_LEN);
        if (!bad)
        begin
            count = (dlen + space - 1) / space;
            if (count < 1)
                count = 1;
            bad = count > MAX_FRAGMENTS;
        end
        if (bad)
        begin
            if (record)
                frag_q.push_back(ERR_DESC);
        end
        else
        begin
            tag_ctr = tag_ctr + 16'd1;
            off = 0;
            rem = dlen;
            for (int k = 0; k < count; k++)
            begin
                flen = (k == count - 1) ? rem : space;
                d.size_word = {(off == 0) ? DISPATCH_FIRST : DISPATCH_LATER, 11'(dlen)};
                d.tag = tag_ctr;
                d.off_units = 8'(off / 8);
                d.src_off = 11'(off);
                d.frag_len = 7'(flen);
                d.frame_len = 7'(hdr + flen);
                d.is_last = (k == count - 1);
                d.is_err = 1'b0;
                if (record)
                    frag_q.push_back(d);
                off += flen;
                rem -= flen;
            end
        end
    endfunction

    task automatic send_request(input logic [10:0] pay, input logic [5:0] comp,
                                input logic [6:0] link, input bit typed,
                                input frag_desc_t want);
        int gap;
        int r;
        in_valid <= 1'b1;
        payload_length <= pay;
        compressed_header_size <= comp;
        link_overhead <= link;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        plan_datagram(pay, comp, link, !typed);
        if (typed)
            frag_q.push_back(want);
        gap = 0;
        if (gap_mode)
        begin
            r = $urandom_range(0, 19);
            if (r >= 18)
                gap = $urandom_range(10, 40);
            else if (r >= 10)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        logic [10:0] pay;
        logic [5:0]  comp;
        logic [6:0]  link;
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            pay = 11'($urandom_range(0, 200));
        else if (r < 9)
            pay = 11'($urandom_range(0, 1280));
        else
            pay = 11'($urandom_range(0, 2047));
        comp = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 40));
        link = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 40));
        send_request(pay, comp, link, 1'b0, NO_DESC);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frag_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [6:0] phy, input logic [6:0] ovh);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAX_PHY_PACKET;
        cfg_wr_data <= phy;
        @(posedge clk);
        cfg_index <= REG_MAX_FRAME_OVERHEAD;
        cfg_wr_data <= ovh;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        phy_size = phy;
        ovh_size = ovh;
    endtask

    // Output side: random stalls, long holds, and the one squeeze that backs the block up.
    initial
    begin : sink
        int r;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze)
            begin
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!sink_mode)
                out_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 63);
                if (r == 0)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
                else
                    out_ready <= (r > 16);
            end
        end
    end

    always @(posedge clk)
    begin
        frag_desc_t got;
        frag_desc_t exp;
        got = '{size_word, frag_tag, offset_units, source_offset, fragment_length,
                frame_length, last, error};
        if (rst_n && out_valid && out_ready)
        begin
            if (frag_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: size %h tag %h off %0d src %0d",
                             got.size_word, got.tag, got.off_units, got.src_off,
                             " len %0d frame %0d last %b err %b",
                             got.frag_len, got.frame_len, got.is_last, got.is_err);
            end
            else
            begin
                exp = frag_q.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: size %h tag %h off %0d src %0d",
                                 exp.size_word, exp.tag, exp.off_units, exp.src_off,
                                 " len %0d frame %0d last %b err %b",
                                 exp.frag_len, exp.frame_len, exp.is_last, exp.is_err);
                        $display("         got: size %h tag %h off %0d src %0d",
                                 got.size_word, got.tag, got.off_units, got.src_off,
                                 " len %0d frame %0d last %b err %b",
                                 got.frag_len, got.frame_len, got.is_last, got.is_err);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int n;
        dir_rows = '{
            '{11'd0,    6'd0,  7'd0,   1'b1, EMPTY_FIRST_DESC},
            '{11'd1280, 6'd40, 7'd0,   1'b0, NO_DESC},
            '{11'd2047, 6'd63, 7'd127, 1'b1, ERR_DESC},
            '{11'd10,   6'd5,  7'd127, 1'b1, ERR_DESC},
            '{11'd90,   6'd6,  7'd10,  1'b0, NO_DESC},
            '{11'd82,   6'd6,  7'd10,  1'b0, NO_DESC},
            '{11'd1023, 6'd1,  7'd0,   1'b0, NO_DESC},
            '{11'd0,    6'd40, 7'd127, 1'b0, NO_DESC},
            '{11'd512,  6'd0,  7'd94,  1'b1, ERR_DESC},
            '{11'd1280, 6'd0,  7'd90,  1'b1, ERR_DESC},
            '{11'd512,  6'd0,  7'd90,  1'b0, NO_DESC},
            '{11'd513,  6'd0,  7'd90,  1'b1, ERR_DESC},
            '{11'd1,    6'd63, 7'd0,   1'b0, NO_DESC},
            '{11'd1365, 6'd42, 7'd85,  1'b0, NO_DESC},
            '{11'd682,  6'd21, 7'd42,  1'b0, NO_DESC},
            '{11'd2047, 6'd0,  7'd0,   1'b0, NO_DESC},
            '{11'd2047, 6'd1,  7'd0,   1'b1, ERR_DESC},
            '{11'd1280, 6'd40, 7'd127, 1'b1, ERR_DESC}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_mode = 1'b1;
        sink_mode = 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(dir_rows[i].pay, dir_rows[i].comp, dir_rows[i].link,
                         dir_rows[i].typed, dir_rows[i].want);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            n = 17;
            gap_mode = $urandom_range(0, 3) != 0;
            sink_mode = $urandom_range(0, 3) != 0;
            case (p)
                0:
                begin
                    set_limits(7'd127, 7'd0);
                    n = 15;
                    gap_mode = 1'b0;
                    sink_mode = 1'b0;
                end
                1:
                begin
                    set_limits(7'd0, 7'd0);
                    n = 4;
                end
                2:
                begin
                    set_limits(7'd127, 7'd127);
                    n = 4;
                end
                3:
                begin
                    set_limits(MAX_PHY_PACKET_RESET, MAX_FRAME_OVERHEAD_RESET);
                    n = 15;
                    gap_mode = 1'b0;
                    squeeze = 1'b1;
                end
                4:
                begin
                    set_limits(7'd0, 7'd127);
                    n = 4;
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        set_limits(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                    else
                        set_limits(7'($urandom_range(40, 127)), 7'($urandom_range(0, 40)));
                end
            endcase
            for (int i = 0; i < n; i++)
                send_random_request();
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && frag_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
